[sv/pnt_pkg.sv]
// pnt_pkg: shared constants of the perfect number test core.
// No dependencies; used by the channel interfaces, the divider and the top level.
`default_nettype none

package pnt_pkg;

  // default width of the tested number
  localparam int NUMBER_BITS_DEF = 16;

  // width and ceiling of the reported divisor sum
  localparam int SUM_BITS = 19;
  localparam int SUM_MAX  = 524287;

  // headroom of the internal sum over the number width (aliquot sum < 16 * n)
  localparam int SUM_HEADROOM = 4;

endpackage

`default_nettype wire

[sv/pnt_channels.sv]
// pnt_channels: valid/ready channel interfaces for requests and results.
// Depends on pnt_pkg for the default number width and the sum width.
`default_nettype none

interface pnt_in_if #(
  parameter int NUMBER_BITS = pnt_pkg::NUMBER_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [NUMBER_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface pnt_out_if;
  logic                          valid;
  logic                          ready;
  logic [pnt_pkg::SUM_BITS-1:0]  divisor_sum;
  logic                          is_perfect;
  logic                          qualifies;

  modport source (output valid, output divisor_sum, output is_perfect, output qualifies,
                  input ready);
  modport sink   (input valid, input divisor_sum, input is_perfect, input qualifies,
                  output ready);
endinterface

`default_nettype wire

[sv/pnt_div.sv]
// pnt_div: restoring divider that yields the remainder, one quotient bit per cycle.
// Depends on pnt_pkg for the default number width; instantiated by perfect_number_test_core.
`default_nettype none

module pnt_div #(
  parameter int NUMBER_BITS = pnt_pkg::NUMBER_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [NUMBER_BITS-1:0] dividend,
  input  wire logic [NUMBER_BITS-1:0] divisor,   // held stable while busy, never zero
  output logic                        done,
  output logic [NUMBER_BITS-1:0]      remainder
);

  localparam int CW = $clog2(NUMBER_BITS + 1);

  logic [NUMBER_BITS-1:0] rem_r, rem_nxt;
  logic [NUMBER_BITS-1:0] shf_r, shf_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  logic [NUMBER_BITS:0]   trial;
  logic                   fits;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_r, shf_r[NUMBER_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      shf_nxt  = dividend;
      cnt_nxt  = CW'(NUMBER_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? NUMBER_BITS'(trial - {1'b0, divisor}) : NUMBER_BITS'(trial);
      shf_nxt = {shf_r[NUMBER_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[sv/perfect_number_test_core.sv]
// perfect_number_test_core: aliquot sum and perfect number test, top level.
// Depends on pnt_pkg, pnt_channels (pnt_in_if, pnt_out_if) and pnt_div.
//
// Usage:
//   in_if  : one request per number; taken when valid and ready are both high.
//   out_if : one result per request: divisor_sum (saturated at 524287),
//            is_perfect and qualifies.
//   Every trial divisor d from 1 to number-1 is tested by one shared restoring
//   divider that settles one bit a cycle; d is added when the remainder is 0.
//   The run time grows with the number, since each trial divisor takes its own pass
//   through the divider; numbers 0 and 1 skip the divider. The core takes one
//   request at a time and holds in_if.ready low from acceptance until the result
//   is registered.
//   A finished result sits in an output register; a new request may be taken
//   while it waits. If the receiver stalls, the next result waits in the core
//   until the register frees up.
//   Reset (rst_n low, synchronous) returns the core to idle with no result
//   pending.
`default_nettype none

module perfect_number_test_core #(
  parameter int NUMBER_BITS = pnt_pkg::NUMBER_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pnt_in_if.sink    in_if,
  pnt_out_if.source out_if
);

  localparam int SUM_BITS = pnt_pkg::SUM_BITS;
  localparam int ACC_BITS = (NUMBER_BITS + pnt_pkg::SUM_HEADROOM > SUM_BITS) ?
                            NUMBER_BITS + pnt_pkg::SUM_HEADROOM : SUM_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [NUMBER_BITS-1:0] num_r, num_nxt;
  logic [NUMBER_BITS-1:0] dvs_r, dvs_nxt;
  logic [ACC_BITS-1:0]    sum_r, sum_nxt;
  logic                   qual_r, qual_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SUM_BITS-1:0]    out_sum_r, out_sum_nxt;
  logic                   out_perf_r, out_perf_nxt;
  logic                   out_qual_r, out_qual_nxt;

  logic                   div_start;
  logic                   div_done;
  logic [NUMBER_BITS-1:0] div_rem;

  logic                   take_in;
  logic                   out_free;
  logic                   last_dvs;
  logic [SUM_BITS-1:0]    sum_sat;
  logic                   sum_eq;

  pnt_div #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (num_r),
    .divisor   (dvs_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign take_in   = in_if.valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_if.ready;
  assign div_start = (state_r == S_START);
  assign last_dvs  = dvs_r == (num_r - NUMBER_BITS'(1));

  // saturate the reported sum; the perfect test uses the full sum
  assign sum_sat = (sum_r > ACC_BITS'(pnt_pkg::SUM_MAX)) ?
                   SUM_BITS'(pnt_pkg::SUM_MAX) : SUM_BITS'(sum_r);
  assign sum_eq  = sum_r == ACC_BITS'(num_r);

  // sequencer: walk the trial divisors through the shared divider
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    dvs_nxt   = dvs_r;
    sum_nxt   = sum_r;
    qual_nxt  = qual_r;
    unique case (state_r)
      S_IDLE: begin
        if (take_in) begin
          num_nxt   = in_if.number;
          dvs_nxt   = NUMBER_BITS'(1);
          sum_nxt   = '0;
          qual_nxt  = in_if.number > NUMBER_BITS'(1);
          state_nxt = (in_if.number > NUMBER_BITS'(1)) ? S_START : S_FIN;
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            sum_nxt = sum_r + ACC_BITS'(dvs_r);
          end
          if (last_dvs) begin
            state_nxt = S_FIN;
          end else begin
            dvs_nxt   = dvs_r + NUMBER_BITS'(1);
            state_nxt = S_START;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    out_perf_nxt  = out_perf_r;
    out_qual_nxt  = out_qual_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_FIN) && out_free) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = qual_r ? sum_sat : '0;
      out_perf_nxt  = qual_r && sum_eq;
      out_qual_nxt  = qual_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    dvs_r      <= dvs_nxt;
    sum_r      <= sum_nxt;
    qual_r     <= qual_nxt;
    out_sum_r  <= out_sum_nxt;
    out_perf_r <= out_perf_nxt;
    out_qual_r <= out_qual_nxt;
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.divisor_sum = out_sum_r;
  assign out_if.is_perfect  = out_perf_r;
  assign out_if.qualifies   = out_qual_r;

endmodule

`default_nettype wire

[test/pnt_result_checker.sv]
// pnt_result_checker: watches the request and result channels of the perfect number core,
// predicts each result from the accepted number and compares it field by field.
// Depends on pnt_pkg (sum width and ceiling) and pnt_channels (pnt_in_if, pnt_out_if).
`default_nettype none

module pnt_result_checker #(
  parameter int NUMBER_BITS = pnt_pkg::NUMBER_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pnt_in_if         in_ch,
  pnt_out_if        out_ch,
  output int        fail_count,
  output int        outstanding
);

  typedef struct packed {
    logic [pnt_pkg::SUM_BITS-1:0] divisor_sum;
    logic                         is_perfect;
    logic                         qualifies;
  } verdict_t;

  verdict_t pending_verdicts[$];

  // aliquot sum by divisor pairs up to the square root; the flag uses the unclipped sum
  function automatic verdict_t aliquot_verdict(logic [NUMBER_BITS-1:0] number);
    verdict_t        v;
    longint unsigned n;
    longint unsigned total;
    longint unsigned d;
    v     = '0;
    n     = 64'(number);
    total = 0;
    if (n > 1) begin
      for (d = 1; d * d <= n; d++) begin
        if (n % d == 0) begin
          total += d;
          if (n / d != d) total += n / d;
        end
      end
      total -= n;
      v.qualifies  = 1'b1;
      v.is_perfect = (total == n);
      if (total > pnt_pkg::SUM_MAX)
        v.divisor_sum = pnt_pkg::SUM_BITS'(pnt_pkg::SUM_MAX);
      else
        v.divisor_sum = total[pnt_pkg::SUM_BITS-1:0];
    end
    return v;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // both channels sampled at the rising edge, before the core updates them
  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pending_verdicts.push_back(aliquot_verdict(in_ch.number));
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result: divisor_sum %0d is_perfect %0b qualifies %0b",
                 out_ch.divisor_sum, out_ch.is_perfect, out_ch.qualifies);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_ch.divisor_sum !== want.divisor_sum) begin
            $error("divisor_sum: expected %0d, got %0d", want.divisor_sum, out_ch.divisor_sum);
            fail_count++;
          end
          if (out_ch.is_perfect !== want.is_perfect) begin
            $error("is_perfect: expected %0b, got %0b", want.is_perfect, out_ch.is_perfect);
            fail_count++;
          end
          if (out_ch.qualifies !== want.qualifies) begin
            $error("qualifies: expected %0b, got %0b", want.qualifies, out_ch.qualifies);
            fail_count++;
          end
        end
      end
      outstanding = pending_verdicts.size();
    end
  end

endmodule

`default_nettype wire

[test/perfect_number_test_core_tb.sv]
// perfect_number_test_core_tb: drives numbers into the perfect number core and gives the verdict.
// Depends on pnt_pkg, pnt_channels, perfect_number_test_core and pnt_result_checker.
`default_nettype none

module perfect_number_test_core_tb;

  localparam int NUMBER_BITS   = pnt_pkg::NUMBER_BITS_DEF;
  localparam int RANDOM_ITEMS  = 100;
  localparam int HOLD_CYCLES   = 1000;
  localparam int DRAIN_CYCLES  = 50;
  // longest silent stretch: one full-width number plus a receiver stall, with margin
  localparam int WATCHDOG_LIMIT = 4000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;

  // receiver and sender mode controls, set by the stimulus process
  bit   rx_steady;
  bit   hold_start;
  bit   tx_steady;

  pnt_in_if #(.NUMBER_BITS(NUMBER_BITS)) in_ch();
  pnt_out_if                             out_ch();

  perfect_number_test_core #(.NUMBER_BITS(NUMBER_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pnt_result_checker #(.NUMBER_BITS(NUMBER_BITS)) result_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random back-pressure, a steady mode and one long hold-off
  initial begin : receiver
    int hold_left;
    hold_left     = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_start) begin
        hold_start   = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // ends the run if neither channel moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // one request: valid stays high until the core takes it
  task automatic offer_number(logic [NUMBER_BITS-1:0] n);
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.number <= n;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic sender_gaps();
    if (!tx_steady) begin
      while ($urandom_range(99) < 32) begin
        @(negedge clk);
        in_ch.valid  <= 1'b0;
        in_ch.number <= NUMBER_BITS'($urandom);
      end
    end
  endtask

  // mostly small numbers; wide ones are rare since latency grows with the value
  function automatic logic [NUMBER_BITS-1:0] draw_number();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(2))
        0:       return 6;
        1:       return 28;
        default: return 496;
      endcase
    end else if (r < 80) begin
      return NUMBER_BITS'($urandom_range(300));
    end else if (r < 97) begin
      return NUMBER_BITS'($urandom_range(2047, 301));
    end
    return NUMBER_BITS'($urandom_range(6000, 2048));
  endfunction

  initial begin : stimulus
    logic [NUMBER_BITS-1:0] directed_numbers[$];
    logic [NUMBER_BITS-1:0] n;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.number = '0;
    rx_steady    = 1'b0;
    tx_steady    = 1'b0;
    hold_start   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero and one, small primes and squares, perfect numbers, powers of two, all ones
    directed_numbers = '{0, 1, 2, 3, 4, 5, 6, 9, 12, 16, 28, 97, 120, 255, 256, 496, 8128,
                         {NUMBER_BITS{1'b1}}};
    foreach (directed_numbers[i]) begin
      sender_gaps();
      offer_number(directed_numbers[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 30) hold_start = 1'b1;
      // let the core drain completely before carrying on
      if (i == 50) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      if (i == 55) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      if (i == 80) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      // short numbers while the receiver holds off, so the core backs up
      if (i >= 30 && i < 40)
        n = NUMBER_BITS'($urandom_range(20, 2));
      else
        n = draw_number();
      sender_gaps();
      offer_number(n);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/pnt_pkg.sv
sv/pnt_channels.sv
sv/pnt_div.sv
sv/perfect_number_test_core.sv
test/pnt_result_checker.sv
test/perfect_number_test_core_tb.sv
